@@ rtl/core/pli_pkg.sv @@
// ----------------------------------------------------------------------------
// pli_pkg
// Types, widths and codes shared by the curve interpolation block.
// ----------------------------------------------------------------------------
package pli_pkg;

  localparam int MAX_POINTS = 64;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int PTS_W      = $clog2(MAX_POINTS + 1);

  localparam int TIME_W     = 48;
  localparam int VAL_W      = 32;
  localparam int NUM_W      = 7;
  localparam int PIDX_W     = 6;
  localparam int X_W        = TIME_W + 1;
  localparam int MAG_W      = VAL_W + 1;
  localparam int ACC_W      = TIME_W + MAG_W;
  localparam int ALU_W      = ACC_W;
  localparam int CNT_W      = $clog2(MAG_W);
  localparam int ENTRY_W    = TIME_W + VAL_W;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_DAY_TODAY  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_POINTS = 1'b1;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [1:0] REG_INTERP = 2'd0;
  localparam logic [1:0] REG_FIRST  = 2'd1;
  localparam logic [1:0] REG_LAST   = 2'd2;
  localparam logic [1:0] REG_EMPTY  = 2'd3;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  typedef struct packed {
    alu_op_e          op;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic                     req_type;
    logic [PIDX_W-1:0]        point_index;
    logic signed [TIME_W-1:0] point_time;
    logic signed [VAL_W-1:0]  point_value;
    logic signed [TIME_W-1:0] expiry;
  } pli_req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] curve_value;
    logic [1:0]              region;
  } pli_res_t;

endpackage

@@ rtl/core/pli_alu.sv @@
// ----------------------------------------------------------------------------
// pli_alu
// Shared wide adder/subtractor used by every step of the sequencer.
// ----------------------------------------------------------------------------
module pli_alu
  import pli_pkg::*;
(
  input  alu_req_t         req_i,
  output logic [ALU_W-1:0] sum_o
);

  always_comb begin
    case (req_i.op)
      ALU_SUB: sum_o = req_i.a - req_i.b;
      default: sum_o = req_i.a + req_i.b;
    endcase
  end

endmodule

@@ rtl/core/pli_mem.sv @@
// ----------------------------------------------------------------------------
// pli_mem
// Curve point store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pli_mem
  import pli_pkg::*;
(
  input  logic               clk_i,
  input  logic               wr_en_i,
  input  logic [IDX_W-1:0]   wr_addr_i,
  input  logic [ENTRY_W-1:0] wr_data_i,
  input  logic [IDX_W-1:0]   rd_addr_i,
  output logic [ENTRY_W-1:0] rd_data_o
);

  logic [ENTRY_W-1:0] mem_q [MAX_POINTS];
  logic [ENTRY_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/core/piecewise_linear_curve_interp.sv @@
// ----------------------------------------------------------------------------
// piecewise_linear_curve_interp
// Piecewise linear curve lookup over a loaded table of time/value points.
//
//   channel   signals                                   transfer when
//   request   start_i, busy_o, req_i                    start_i & !busy_o
//   result    result_valid_o, result_o                  result_valid_o
//   config    cfg_valid_i, cfg_ready_o, cfg_index_i,    cfg_valid_i & cfg_ready_o
//             cfg_data_i
//
// A point write leaves busy_o low. A query to an empty
// table gives its result the next cycle. Otherwise the sequencer scans one
// point per cycle through the single read port, then runs four setup
// subtractions, a 33-step shift-add multiply and a 33-step restoring divide
// on the shared adder. The table is not cleared by reset. Results cannot
// be stalled; each one is shown for one cycle.
// ----------------------------------------------------------------------------
module piecewise_linear_curve_interp
  import pli_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  pli_req_t             req_i,
  output logic                 result_valid_o,
  output pli_res_t             result_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [TIME_W-1:0]    cfg_data_i
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_NUM,
    S_DEN,
    S_DY,
    S_MAG,
    S_MUL,
    S_DIV,
    S_FIN
  } state_e;

  state_e                   state_q, state_d;
  logic                     valid_q, valid_d;
  pli_res_t                 res_q, res_d;
  logic signed [TIME_W-1:0] day_q, day_d;
  logic [NUM_W-1:0]         npts_q, npts_d;
  logic [PTS_W-1:0]         n_q, n_d;
  logic signed [X_W-1:0]    x_q, x_d;
  logic [IDX_W-1:0]         idx_q, idx_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [TIME_W-1:0]        t1_q, t1_d, t2_q, t2_d;
  logic [VAL_W-1:0]         v1_q, v1_d, v2_q, v2_d;
  logic [TIME_W-1:0]        num_q, num_d, den_q, den_d;
  logic                     neg_q, neg_d;
  logic [MAG_W-1:0]         mag_q, mag_d;
  logic [ACC_W-1:0]         acc_q, acc_d;
  logic [TIME_W-1:0]        rem_q, rem_d;

  alu_req_t                 alu_req;
  logic [ALU_W-1:0]         alu_sum;
  logic                     alu_ge;
  logic                     wr_en;
  logic [IDX_W-1:0]         rd_addr;
  logic [ENTRY_W-1:0]       rd_data;
  logic [TIME_W-1:0]        rd_time;
  logic [VAL_W-1:0]         rd_val;
  logic [PTS_W-1:0]         n_sat;
  logic                     at_last;

  pli_alu u_alu (
    .req_i (alu_req),
    .sum_o (alu_sum)
  );

  pli_mem u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (IDX_W'(req_i.point_index)),
    .wr_data_i ({req_i.point_time, req_i.point_value}),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign rd_time = rd_data[ENTRY_W-1:VAL_W];
  assign rd_val  = rd_data[VAL_W-1:0];
  assign alu_ge  = ~alu_sum[ALU_W-1];
  assign n_sat   = (32'(npts_q) > MAX_POINTS) ? PTS_W'(MAX_POINTS) : PTS_W'(npts_q);
  assign at_last = ((PTS_W'(idx_q) + PTS_W'(1)) == n_q);

  always_comb begin
    state_d = state_q;
    valid_d = 1'b0;
    res_d   = res_q;
    day_d   = day_q;
    npts_d  = npts_q;
    n_d     = n_q;
    x_d     = x_q;
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    t1_d    = t1_q;
    t2_d    = t2_q;
    v1_d    = v1_q;
    v2_d    = v2_q;
    num_d   = num_q;
    den_d   = den_q;
    neg_d   = neg_q;
    mag_d   = mag_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    wr_en   = 1'b0;
    rd_addr = '0;
    alu_req = '{op: ALU_ADD, a: '0, b: '0};

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_DAY_TODAY:  day_d  = cfg_data_i;
        CFG_NUM_POINTS: npts_d = cfg_data_i[NUM_W-1:0];
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        alu_req = '{op: ALU_SUB, a: ALU_W'(signed'(req_i.expiry)), b: ALU_W'(day_q)};
        if (start_i) begin
          if (req_i.req_type == REQ_WRITE) begin
            wr_en = (32'(req_i.point_index) < MAX_POINTS);
          end else begin
            n_d   = n_sat;
            x_d   = alu_sum[X_W-1:0];
            idx_d = '0;
            if (n_sat == '0) begin
              valid_d           = 1'b1;
              res_d.curve_value = '0;
              res_d.region      = REG_EMPTY;
            end else begin
              state_d = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        rd_addr = IDX_W'(idx_q + 1'b1);
        alu_req = '{op: ALU_SUB, a: ALU_W'(signed'(rd_time)), b: ALU_W'(x_q)};
        if (alu_ge && (idx_q != '0)) begin
          t2_d    = rd_time;
          v2_d    = rd_val;
          state_d = S_NUM;
        end else if ((idx_q == '0) && (alu_ge || (n_q == PTS_W'(1)))) begin
          valid_d           = 1'b1;
          res_d.curve_value = rd_val;
          res_d.region      = REG_FIRST;
          state_d           = S_IDLE;
        end else if (at_last) begin
          valid_d           = 1'b1;
          res_d.curve_value = rd_val;
          res_d.region      = REG_LAST;
          state_d           = S_IDLE;
        end else begin
          t1_d  = rd_time;
          v1_d  = rd_val;
          idx_d = IDX_W'(idx_q + 1'b1);
        end
      end
      S_NUM: begin
        alu_req = '{op: ALU_SUB, a: ALU_W'(x_q), b: ALU_W'(signed'(t1_q))};
        num_d   = alu_sum[TIME_W-1:0];
        state_d = S_DEN;
      end
      S_DEN: begin
        alu_req = '{op: ALU_SUB, a: ALU_W'(signed'(t2_q)), b: ALU_W'(signed'(t1_q))};
        den_d   = alu_sum[TIME_W-1:0];
        state_d = S_DY;
      end
      S_DY: begin
        alu_req = '{op: ALU_SUB, a: ALU_W'(signed'(v2_q)), b: ALU_W'(signed'(v1_q))};
        neg_d   = alu_sum[ALU_W-1];
        mag_d   = alu_sum[MAG_W-1:0];
        state_d = S_MAG;
      end
      S_MAG: begin
        alu_req = '{op: ALU_SUB, a: '0, b: ALU_W'(signed'(mag_q))};
        if (neg_q) begin
          mag_d = alu_sum[MAG_W-1:0];
        end
        acc_d   = '0;
        cnt_d   = '0;
        state_d = S_MUL;
      end
      S_MUL: begin
        alu_req = '{op: ALU_ADD,
                    a: ALU_W'({acc_q[ACC_W-2:0], 1'b0}),
                    b: mag_q[MAG_W-1] ? ALU_W'(num_q) : '0};
        acc_d = alu_sum[ACC_W-1:0];
        mag_d = {mag_q[MAG_W-2:0], 1'b0};
        cnt_d = CNT_W'(cnt_q + 1'b1);
        if (cnt_q == CNT_W'(MAG_W - 1)) begin
          rem_d   = alu_sum[ACC_W-1:MAG_W];
          cnt_d   = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        alu_req = '{op: ALU_SUB,
                    a: ALU_W'({rem_q, acc_q[MAG_W-1]}),
                    b: ALU_W'(den_q)};
        rem_d = alu_ge ? alu_sum[TIME_W-1:0] : {rem_q[TIME_W-2:0], acc_q[MAG_W-1]};
        acc_d[MAG_W-1:0] = {acc_q[MAG_W-2:0], alu_ge};
        cnt_d = CNT_W'(cnt_q + 1'b1);
        if (cnt_q == CNT_W'(MAG_W - 1)) begin
          cnt_d   = '0;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        alu_req = '{op: neg_q ? ALU_SUB : ALU_ADD,
                    a: ALU_W'(signed'(v1_q)),
                    b: ALU_W'(acc_q[MAG_W-1:0])};
        valid_d           = 1'b1;
        res_d.curve_value = alu_sum[VAL_W-1:0];
        res_d.region      = REG_INTERP;
        state_d           = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
      res_q   <= '0;
      day_q   <= '0;
      npts_q  <= '0;
      n_q     <= '0;
      x_q     <= '0;
      idx_q   <= '0;
      cnt_q   <= '0;
      t1_q    <= '0;
      t2_q    <= '0;
      v1_q    <= '0;
      v2_q    <= '0;
      num_q   <= '0;
      den_q   <= '0;
      neg_q   <= 1'b0;
      mag_q   <= '0;
      acc_q   <= '0;
      rem_q   <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      res_q   <= res_d;
      day_q   <= day_d;
      npts_q  <= npts_d;
      n_q     <= n_d;
      x_q     <= x_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      t1_q    <= t1_d;
      t2_q    <= t2_d;
      v1_q    <= v1_d;
      v2_q    <= v2_d;
      num_q   <= num_d;
      den_q   <= den_d;
      neg_q   <= neg_d;
      mag_q   <= mag_d;
      acc_q   <= acc_d;
      rem_q   <= rem_d;
    end
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = valid_q;
  assign result_o       = res_q;
  assign cfg_ready_o    = 1'b1;

  a_result_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy_o)
    else $error("result shown while sequencer busy");

  a_den_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (den_q != '0))
    else $error("zero divisor in divide phase");

  a_rem_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < den_q))
    else $error("partial remainder not below divisor");

  a_num_le_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL) |-> (num_q <= den_q))
    else $error("offset exceeds segment length");

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Regression for the piecewise linear curve lookup. Point writes and queries
// go in through the start/busy port, the date offset and the point count
// through the config channel. A lookup model tracks the table and registers,
// and every query transfer queues the value and region it must return. Each
// result strobe is checked field by field against the oldest entry.
// ----------------------------------------------------------------------------
module tb;
  import pli_pkg::*;

  localparam longint TIME_MAX    = 64'sh7FFF_FFFF_FFFF;
  localparam longint TIME_MIN    = -64'sh8000_0000_0000;
  localparam longint VAL_MAX     = 64'sh7FFF_FFFF;
  localparam longint VAL_MIN     = -64'sh8000_0000;
  localparam int     STALL_LIMIT = 2000;
  localparam int     ITEM_TARGET = 1900;
  localparam int     REQ_W       = $bits(pli_req_t);

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 start_i;
  logic                 busy_o;
  pli_req_t             req_i;
  logic                 result_valid_o;
  pli_res_t             result_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [TIME_W-1:0]    cfg_data_i;

  longint      pt_time [MAX_POINTS];
  longint      pt_value[MAX_POINTS];
  bit          pt_loaded[MAX_POINTS];
  longint      today_days;
  int unsigned active_points;
  pli_res_t    pending_lookups[$];
  int          errors;
  int          items_sent;
  int          quiet_cycles;
  bit          gaps_on;

  piecewise_linear_curve_interp i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .req_i          (req_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint rand64();
    return longint'({$urandom, $urandom});
  endfunction

  function automatic int loaded_prefix();
    int k;
    k = 0;
    while (k < MAX_POINTS && pt_loaded[k]) k++;
    return k;
  endfunction

  function automatic pli_res_t curve_lookup(input logic signed [TIME_W-1:0] expiry);
    pli_res_t     r;
    longint       x;
    longint       y;
    longint       dy;
    longint       x1;
    int           n;
    bit           hit;
    logic [127:0] mag;
    logic [127:0] seg_offset;
    logic [127:0] span;
    logic [127:0] q;
    n = (active_points > MAX_POINTS) ? MAX_POINTS : active_points;
    x = longint'($signed(expiry)) - today_days;
    hit = 1'b0;
    if (n == 0) begin
      y = 0;
      r.region = REG_EMPTY;
    end else if (n == 1 || pt_time[0] >= x) begin
      y = pt_value[0];
      r.region = REG_FIRST;
    end else begin
      y = pt_value[n-1];
      r.region = REG_LAST;
      for (int i = 1; i < n && !hit; i++) begin
        if (pt_time[i] >= x) begin
          x1         = pt_time[i-1];
          dy         = pt_value[i] - pt_value[i-1];
          mag        = (dy < 0) ? 128'(-dy) : 128'(dy);
          seg_offset = 128'(x - x1);
          span       = 128'(pt_time[i] - x1);
          q          = (mag * seg_offset) / span;
          y    = (dy < 0) ? pt_value[i-1] - longint'(q[63:0])
                          : pt_value[i-1] + longint'(q[63:0]);
          r.region = REG_INTERP;
          hit = 1'b1;
        end
      end
    end
    r.curve_value = y[VAL_W-1:0];
    return r;
  endfunction

  // Check results, then apply config and item transfers to the lookup model.
  always @(posedge clk_i) begin
    pli_res_t exp_res;
    if (rst_ni) begin
      if (result_valid_o) begin
        if (pending_lookups.size() == 0) begin
          $display("%0t: result with no lookup pending, expected none, got %h",
                   $time, result_o);
          errors++;
        end else begin
          exp_res = pending_lookups.pop_front();
          if (result_o.curve_value !== exp_res.curve_value) begin
            $display("%0t: curve_value expected %h, got %h",
                     $time, exp_res.curve_value, result_o.curve_value);
            errors++;
          end
          if (result_o.region !== exp_res.region) begin
            $display("%0t: region expected %0d, got %0d",
                     $time, exp_res.region, result_o.region);
            errors++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_DAY_TODAY) begin
          today_days = longint'($signed(cfg_data_i));
        end else if (cfg_index_i == CFG_NUM_POINTS) begin
          active_points = 32'(cfg_data_i[NUM_W-1:0]);
        end
      end
      if (start_i && !busy_o) begin
        if (req_i.req_type == REQ_WRITE) begin
          pt_time[req_i.point_index]   = longint'($signed(req_i.point_time));
          pt_value[req_i.point_index]  = longint'($signed(req_i.point_value));
          pt_loaded[req_i.point_index] = 1'b1;
        end else begin
          pending_lookups.push_back(curve_lookup(req_i.expiry));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic hold_off(input int cycles);
    start_i = 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  // Leave start high on return; the caller drives the next item or drops it.
  task automatic send(input pli_req_t item);
    if (gaps_on && $urandom_range(99) < 15) hold_off($urandom_range(1, 6));
    start_i = 1'b1;
    req_i   = item;
    do @(posedge clk_i); while (busy_o);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic settle();
    start_i = 1'b0;
    do @(negedge clk_i); while (pending_lookups.size() != 0 || busy_o);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] data);
    start_i     = 1'b0;
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    cfg_data_i  = TIME_W'(rand64());
  endtask

  task automatic set_point_count(input int count);
    logic [TIME_W-1:0] data;
    data = TIME_W'(rand64());
    data[NUM_W-1:0] = NUM_W'(count);
    write_reg(CFG_NUM_POINTS, data);
  endtask

  task automatic write_point(input int idx, input longint t, input longint v);
    pli_req_t item;
    item             = REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
    item.req_type    = REQ_WRITE;
    item.point_index = PIDX_W'(idx);
    item.point_time  = t[TIME_W-1:0];
    item.point_value = v[VAL_W-1:0];
    send(item);
  endtask

  task automatic query(input longint expiry);
    pli_req_t item;
    item          = REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
    item.req_type = REQ_QUERY;
    item.expiry   = expiry[TIME_W-1:0];
    send(item);
  endtask

  // Aim a query at a point, inside a segment or near a point, or anywhere.
  task automatic probe();
    int           n;
    int           i;
    int           pick;
    longint       x;
    logic [63:0]  rnd;
    n    = (active_points > MAX_POINTS) ? MAX_POINTS : active_points;
    pick = $urandom_range(99);
    if (n == 0 || pick < 15) begin
      query(rand64());
    end else begin
      i = $urandom_range(n - 1);
      if (pick < 35) begin
        x = pt_time[i];
      end else if (pick < 70 && i > 0 && pt_time[i] > pt_time[i-1]) begin
        rnd = {$urandom, $urandom};
        x = pt_time[i-1] + 1 + longint'(rnd % $unsigned(pt_time[i] - pt_time[i-1]));
      end else begin
        x = pt_time[i] + (rand64() >>> $urandom_range(40, 62));
      end
      query(x + today_days);
    end
  endtask

  // Load a non-decreasing curve at indices 0..n-1, with queries mixed in.
  task automatic load_curve(input int n);
    longint t;
    longint step;
    longint step_mask;
    bit     wide;
    wide = ($urandom_range(7) == 0);
    if (wide) begin
      t    = TIME_MIN + $urandom_range(0, 1000);
      step = (TIME_MAX - t) / n;
    end else begin
      t         = rand64() >>> (64 - $urandom_range(8, 45));
      step_mask = (64'sd1 <<< $urandom_range(0, 36)) - 1;
    end
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 25) probe();
      write_point(i, t, (i % 9 == 8) ? VAL_MIN : longint'($signed($urandom)));
      if (!wide) begin
        step = ($urandom_range(15) == 0) ? 0 : (rand64() & step_mask);
      end
      t = t + step;
    end
  endtask

  task automatic test_empty_table();
    query(TIME_MAX);
    query(TIME_MIN);
    query(0);
  endtask

  task automatic test_curve_extremes();
    write_point(0, TIME_MIN, VAL_MIN);
    write_point(1, 0, VAL_MAX);
    write_point(2, TIME_MAX, VAL_MIN);
    settle();
    write_reg(CFG_DAY_TODAY, '0);
    set_point_count(1);
    query(5);
    settle();
    set_point_count(3);
    query(TIME_MIN);
    query(TIME_MIN + 1);
    query(-1);
    query(0);
    query(1);
    query(TIME_MAX - 1);
    query(TIME_MAX);
    settle();
    write_reg(CFG_DAY_TODAY, TIME_MIN[TIME_W-1:0]);
    query(TIME_MAX);
    settle();
    write_reg(CFG_DAY_TODAY, TIME_MAX[TIME_W-1:0]);
    query(TIME_MIN);
    settle();
    write_reg(CFG_DAY_TODAY, '0);
  endtask

  task automatic test_random_curves();
    int n;
    int prefix;
    int count;
    int lookups;
    while (items_sent < ITEM_TARGET) begin
      gaps_on = !(items_sent > 700 && items_sent < 1000);
      n = 0;
      if ($urandom_range(9) < 7) begin
        n = ($urandom_range(5) == 0) ? $urandom_range(9, MAX_POINTS) : $urandom_range(1, 8);
        load_curve(n);
      end
      settle();
      case ($urandom_range(5))
        0: write_reg(CFG_DAY_TODAY, '0);
        1: write_reg(CFG_DAY_TODAY, TIME_W'(rand64() >>> 40));
        2: write_reg(CFG_DAY_TODAY, TIME_W'(rand64()));
        default: ;
      endcase
      prefix = loaded_prefix();
      if (n > 0 && $urandom_range(9) < 7) begin
        count = n;
      end else begin
        count = $urandom_range(0, prefix);
      end
      if (prefix == MAX_POINTS && $urandom_range(4) == 0) begin
        count = $urandom_range(MAX_POINTS, 127);
      end
      set_point_count(count);
      lookups = $urandom_range(8, 40);
      for (int k = 0; k < lookups; k++) begin
        if ($urandom_range(99) < 10) begin
          write_point($urandom_range(MAX_POINTS - 1), rand64(), rand64());
        end else begin
          probe();
        end
        if ($urandom_range(99) < 3) settle();
      end
      settle();
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    req_i       = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_DAY_TODAY;
    cfg_data_i  = '0;
    today_days    = 0;
    active_points = 0;
    errors        = 0;
    items_sent    = 0;
    quiet_cycles  = 0;
    gaps_on       = 1'b1;
    foreach (pt_time[i]) begin
      pt_time[i]   = 0;
      pt_value[i]  = 0;
      pt_loaded[i] = 1'b0;
    end
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_empty_table();
    test_curve_extremes();
    test_random_curves();

    settle();
    repeat (16) @(negedge clk_i);
    if (errors == 0 && pending_lookups.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/pli_pkg.sv
rtl/core/pli_alu.sv
rtl/core/pli_mem.sv
rtl/core/piecewise_linear_curve_interp.sv
verif/tb.sv
